FILE: rtl/psbb_pkg.sv
// Shared types, constants and helpers of the polyline stroke band block.
package psbb_pkg;

  // Default mesh capacity in vertices.
  localparam int unsigned MESH_VERTEX_LIMIT_DEF = 65535;

  // A join whose cross product of unit directions (Q2.30) is below this is straight.
  localparam logic [43:0] CROSS_EPS = 44'd107375;

  // Rounding constant for the Q.16 side offset product.
  localparam logic [42:0] ROUND_HALF = 43'd32768;

  // Largest magnitude of a Q1.15 unit component.
  localparam logic [16:0] UNIT_ONE = 17'd32768;

  // Reset value of the stroke width register.
  localparam logic [23:0] WIDTH_RESET = 24'd256;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_STROKE_WIDTH = 2'd0;
  localparam logic [1:0] REG_CLOSED_PATH  = 2'd1;
  localparam logic [1:0] REG_BASE_INDEX   = 2'd2;

  // Input opcodes.
  localparam logic OPC_SEGMENT = 1'b0;
  localparam logic OPC_JOIN    = 1'b1;

  // Result item kinds.
  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  // One input point.
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               final_point;
  } point_in_t;

  // One mesh result item.
  typedef struct packed {
    logic               item_kind;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        index_a;
    logic [15:0]        index_b;
    logic [15:0]        index_c;
    logic               last_of_run;
  } mesh_out_t;

  // A stored point.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  // Controls from the sequencer to the result buffer.
  typedef struct packed {
    logic push;
    logic flush;
  } out_ctl_t;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIR0,
    S_WAIT0,
    S_DIR1,
    S_WAIT1,
    S_CROSS_A,
    S_CROSS_B,
    S_CROSS_CHK,
    S_SIDE,
    S_EMIT,
    S_NEXT_OP,
    S_FINISH
  } seq_state_t;

  // Direction unit states.
  typedef enum logic [3:0] {
    D_IDLE,
    D_NORM,
    D_SQX,
    D_SQY,
    D_ROOT,
    D_LDX,
    D_DIVX,
    D_LDY,
    D_DIVY,
    D_DONE
  } dir_state_t;

  // Saturate a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/psbb_dir.sv
// Iterative unit direction: normalize, integer square root and two divisions.
module psbb_dir (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  output logic               done,
  output logic               zero,
  output logic signed [16:0] ux,
  output logic signed [16:0] uy
);
  import psbb_pkg::*;

  dir_state_t state, state_next;

  logic        sgn_x, sgn_y;
  logic [32:0] ax, ay;
  logic [60:0] acc;
  logic [61:0] root;
  logic [60:0] bitv;
  logic [30:0] len;
  logic [30:0] rem;
  logic [16:0] nlow;
  logic [16:0] quo;
  logic [4:0]  dcnt;

  // Combinational helpers.
  logic [32:0] mx;
  logic [29:0] sq_op;
  logic [59:0] sq;
  logic [61:0] root_sum;
  logic        root_take;
  logic [61:0] root_new;
  logic [45:0] num;
  logic [31:0] trial;
  logic        qbit;
  logic [16:0] q_fin;
  logic [16:0] q_clamp;

  assign mx    = (ax > ay) ? ax : ay;
  assign sq_op = (state == D_SQY) ? ay[29:0] : ax[29:0];
  assign sq    = sq_op * sq_op;

  // One root digit per cycle.
  assign root_sum  = root + {1'b0, bitv};
  assign root_take = {1'b0, acc} >= root_sum;
  assign root_new  = root_take ? ((root >> 1) + {1'b0, bitv}) : (root >> 1);

  // Numerator of the rounded quotient, and one restoring division step.
  assign num     = {1'b0, ((state == D_LDY) ? ay[29:0] : ax[29:0]), 15'd0}
                 + {16'd0, len[30:1]};
  assign trial   = {rem, nlow[16]};
  assign qbit    = trial >= {1'b0, len};
  assign q_fin   = {quo[15:0], qbit};
  assign q_clamp = (q_fin > UNIT_ONE) ? UNIT_ONE : q_fin;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: begin
        if (start) begin
          state_next = (dx == '0 && dy == '0) ? D_DONE : D_NORM;
        end
      end
      D_NORM: begin
        if (mx[32:30] == 3'd0 && mx[29]) begin
          state_next = D_SQX;
        end
      end
      D_SQX:  state_next = D_SQY;
      D_SQY:  state_next = D_ROOT;
      D_ROOT: begin
        if (bitv[0]) begin
          state_next = D_LDX;
        end
      end
      D_LDX:  state_next = D_DIVX;
      D_DIVX: begin
        if (dcnt == 5'd16) begin
          state_next = D_LDY;
        end
      end
      D_LDY:  state_next = D_DIVY;
      D_DIVY: begin
        if (dcnt == 5'd16) begin
          state_next = D_DONE;
        end
      end
      D_DONE: state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done = (state == D_DONE);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (start) begin
          sgn_x <= dx[32];
          sgn_y <= dy[32];
          ax    <= dx[32] ? 33'(-dx) : 33'(dx);
          ay    <= dy[32] ? 33'(-dy) : 33'(dy);
          zero  <= (dx == '0 && dy == '0);
        end
      end
      D_NORM: begin
        if (mx[32:30] != 3'd0) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (!mx[29]) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      D_SQX: begin
        acc <= {1'b0, sq};
      end
      D_SQY: begin
        acc  <= acc + {1'b0, sq};
        root <= '0;
        bitv <= {1'b1, 60'd0};
      end
      D_ROOT: begin
        if (root_take) begin
          acc <= 61'(({1'b0, acc}) - root_sum);
        end
        root <= root_new;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          len <= root_new[30:0];
        end
      end
      D_LDX, D_LDY: begin
        rem  <= {2'b00, num[45:17]};
        nlow <= num[16:0];
        quo  <= '0;
        dcnt <= '0;
      end
      D_DIVX, D_DIVY: begin
        rem  <= qbit ? 31'(trial - {1'b0, len}) : trial[30:0];
        nlow <= nlow << 1;
        quo  <= q_fin;
        dcnt <= dcnt + 5'd1;
        if (dcnt == 5'd16) begin
          if (state == D_DIVX) begin
            ux <= sgn_x ? 17'(-q_clamp) : q_clamp;
          end else begin
            uy <= sgn_y ? 17'(-q_clamp) : q_clamp;
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A nonzero direction always gives a nonzero unit vector.
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !zero |-> (ux != '0 || uy != '0))
    else $error("unit direction of a nonzero vector is zero");

  // The root search walks a single bit.
  a_root_onehot: assert property (@(posedge clk) disable iff (rst)
    state == D_ROOT |-> $onehot(bitv))
    else $error("root bit is not one-hot");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == D_DIVX || state == D_DIVY) |-> rem < len)
    else $error("division remainder out of range");
`endif

endmodule

FILE: rtl/psbb_out.sv
// Result buffer: one pending item so that the last of a run can be marked, then the output register.
module psbb_out (
  input  logic                clk,
  input  logic                rst,
  input  psbb_pkg::out_ctl_t  ctl,
  input  psbb_pkg::mesh_out_t data,
  output logic                can_take,
  output logic                mesh_valid,
  input  logic                mesh_ready,
  output psbb_pkg::mesh_out_t mesh
);
  import psbb_pkg::*;

  logic      pvalid;
  mesh_out_t pdata;
  logic      out_free;
  mesh_out_t mid_item, end_item;

  assign out_free = !mesh_valid || mesh_ready;
  assign can_take = !pvalid || out_free;

  // The pending item marked as inside or at the end of its run.
  always_comb begin
    mid_item             = pdata;
    mid_item.last_of_run = 1'b0;
    end_item             = pdata;
    end_item.last_of_run = 1'b1;
  end

  // Control: valid bits of the pending and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid     <= 1'b0;
      mesh_valid <= 1'b0;
    end else begin
      if (ctl.push && can_take) begin
        pvalid <= 1'b1;
        if (pvalid) begin
          mesh_valid <= 1'b1;
        end else if (mesh_ready) begin
          mesh_valid <= 1'b0;
        end
      end else if (ctl.flush && can_take && pvalid) begin
        pvalid     <= 1'b0;
        mesh_valid <= 1'b1;
      end else if (mesh_ready) begin
        mesh_valid <= 1'b0;
      end
    end
  end

  // Payload moves.
  always_ff @(posedge clk) begin
    if (ctl.push && can_take) begin
      pdata <= data;
      if (pvalid) begin
        mesh <= mid_item;
      end
    end else if (ctl.flush && can_take && pvalid) begin
      mesh <= end_item;
    end
  end

endmodule

FILE: rtl/polyline_stroke_band_bevel.sv
// Top level: configuration registers, point state and the stroke sequencer.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------
//  point    | point_valid / point_ready     | point (point_in_t)
//  mesh     | mesh_valid / mesh_ready       | mesh (mesh_out_t)
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One point is taken at a time; point_ready is low until its results are queued.
// A point runs up to two segments or joins; each costs one or two unit directions in
// the shared direction unit (start, normalize, root, divide, done), plus setup, cross,
// offsets and emission.
// Mesh stalls hold the sequencer only when the pending and output stages are full.
// Reset is synchronous; no clearing pass is needed.
module polyline_stroke_band_bevel #(
  parameter int unsigned MESH_VERTEX_LIMIT = psbb_pkg::MESH_VERTEX_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_ready,
  input  psbb_pkg::point_in_t point,
  output logic                mesh_valid,
  input  logic                mesh_ready,
  output psbb_pkg::mesh_out_t mesh,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import psbb_pkg::*;

  seq_state_t state, state_next;

  // Configuration.
  logic [23:0] stroke_width;
  logic        closed_path;
  logic [15:0] base_index;

  // Persistent point state.
  pt_t         first_pt, win0, win1, tail_pt;
  logic [1:0]  seen;
  logic [16:0] nvi;
  logic        halted;

  // Current item.
  pt_t         cur_pt;
  logic        cur_join, cur_fin, cur_closed;
  logic [1:0]  cur_c;

  // Current operation.
  logic               op_idx;
  pt_t                pa, pb, pc;
  logic signed [16:0] d0x, d0y, d1x, d1y;
  logic signed [42:0] prod1;
  logic signed [43:0] cr;
  logic signed [24:0] off [4];
  logic [1:0]         scnt;
  logic [2:0]         ecnt;
  logic [16:0]        vbase;

  // Direction unit hookup.
  logic               dir_start, dir_done, dir_zero;
  logic signed [32:0] dir_dx, dir_dy;
  logic signed [16:0] dir_ux, dir_uy;

  // Result buffer hookup.
  out_ctl_t  ctl;
  mesh_out_t emit_data;
  logic      can_take;

  // Write strobe of the configuration port.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_STROKE_WIDTH: prdata = {8'd0, stroke_width};
      REG_CLOSED_PATH:  prdata = {31'd0, closed_path};
      REG_BASE_INDEX:   prdata = {16'd0, base_index};
      default:          prdata = '0;
    endcase
  end

  // Operation selection.
  logic        op_ok;
  pt_t         qa, qb, qc;
  logic [17:0] need;
  logic        cap_over;
  logic        op_run;

  always_comb begin
    op_ok = 1'b0;
    qa    = win1;
    qb    = cur_pt;
    qc    = first_pt;
    if (!cur_join) begin
      if (!op_idx) begin
        op_ok = (cur_c != 2'd0);
      end else begin
        op_ok = cur_fin && cur_closed && (cur_c != 2'd0);
        qa    = cur_pt;
        qb    = first_pt;
      end
    end else begin
      if (!op_idx) begin
        qc = cur_pt;
        qb = win1;
        if (cur_c == 2'd1) begin
          op_ok = cur_closed;
          qa    = tail_pt;
        end else begin
          op_ok = (cur_c == 2'd2);
          qa    = win0;
        end
      end else begin
        op_ok = cur_fin && cur_closed && (cur_c != 2'd0);
        qa    = win1;
        qb    = cur_pt;
        qc    = first_pt;
      end
    end
  end

  assign need     = {1'b0, nvi} + (cur_join ? 18'd3 : 18'd4);
  assign cap_over = need > 18'(MESH_VERTEX_LIMIT);
  assign op_run   = op_ok && (stroke_width != '0) && !halted;

  // Shared multiplier for the cross product and the side offsets.
  logic signed [17:0] ma;
  logic signed [24:0] mb;
  logic signed [42:0] prod;
  logic signed [17:0] su;
  logic        [17:0] smag;
  logic        [42:0] srnd;
  logic signed [24:0] soff;

  always_comb begin
    unique case (scnt)
      2'd0:    su = -18'(d0y);
      2'd1:    su = 18'(d0x);
      2'd2:    su = -18'(d1y);
      2'd3:    su = 18'(d1x);
      default: su = '0;
    endcase
    smag = su[17] ? 18'(-su) : 18'(su);
    ma   = $signed(smag);
    mb   = $signed({1'b0, stroke_width});
    if (state == S_CROSS_A) begin
      ma = 18'(d0x);
      mb = 25'(d1y);
    end else if (state == S_CROSS_B) begin
      ma = 18'(d0y);
      mb = 25'(d1x);
    end
  end

  assign prod = ma * mb;
  assign srnd = 43'(prod) + ROUND_HALF;
  assign soff = su[17] ? -$signed({1'b0, srnd[39:16]}) : $signed({1'b0, srnd[39:16]});

  // Cross product tests.
  logic [43:0] cr_abs;
  logic        cr_pos;
  assign cr_abs = cr[43] ? 44'(-cr) : 44'(cr);
  assign cr_pos = !cr[43] && (cr != '0);

  // Emitted result item.
  logic               last_emit;
  logic               is_vertex;
  pt_t                bpt;
  logic signed [24:0] ox, oy;
  logic               oneg, ouse;
  logic signed [33:0] ex, ey;

  assign last_emit = cur_join ? (ecnt == 3'd3) : (ecnt == 3'd5);
  assign is_vertex = cur_join ? (ecnt < 3'd3) : (ecnt < 3'd4);

  always_comb begin
    bpt  = pb;
    ox   = off[0];
    oy   = off[1];
    oneg = 1'b0;
    ouse = 1'b1;
    emit_data = '0;
    if (!cur_join) begin
      bpt  = (ecnt < 3'd2) ? pa : pb;
      oneg = ecnt[0];
    end else begin
      ouse = (ecnt != 3'd0);
      oneg = cr_pos;
      if (ecnt == 3'd2) begin
        ox = off[2];
        oy = off[3];
      end
    end
    ex = ouse ? (oneg ? -34'(ox) : 34'(ox)) : '0;
    ey = ouse ? (oneg ? -34'(oy) : 34'(oy)) : '0;
    if (is_vertex) begin
      emit_data.item_kind = KIND_VERTEX;
      emit_data.vertex_x  = sat32(34'(bpt.x) + ex);
      emit_data.vertex_y  = sat32(34'(bpt.y) + ey);
      emit_data.index_a   = nvi[15:0];
    end else begin
      emit_data.item_kind = KIND_TRIANGLE;
      emit_data.index_a   = vbase[15:0];
      if (cur_join) begin
        emit_data.index_b = 16'(vbase + 17'd1);
        emit_data.index_c = 16'(vbase + 17'd2);
      end else if (ecnt == 3'd4) begin
        emit_data.index_b = 16'(vbase + 17'd2);
        emit_data.index_c = 16'(vbase + 17'd3);
      end else begin
        emit_data.index_b = 16'(vbase + 17'd3);
        emit_data.index_c = 16'(vbase + 17'd1);
      end
    end
  end

  assign dir_dx = (state == S_DIR1) ? (33'(pc.x) - 33'(pb.x)) : (33'(pb.x) - 33'(pa.x));
  assign dir_dy = (state == S_DIR1) ? (33'(pc.y) - 33'(pb.y)) : (33'(pb.y) - 33'(pa.y));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (point_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP:  state_next = (op_run && !cap_over) ? S_DIR0 : S_NEXT_OP;
      S_DIR0:   state_next = S_WAIT0;
      S_WAIT0: begin
        if (dir_done) begin
          if (dir_zero) begin
            state_next = S_NEXT_OP;
          end else begin
            state_next = cur_join ? S_DIR1 : S_SIDE;
          end
        end
      end
      S_DIR1:   state_next = S_WAIT1;
      S_WAIT1: begin
        if (dir_done) begin
          state_next = dir_zero ? S_NEXT_OP : S_CROSS_A;
        end
      end
      S_CROSS_A:   state_next = S_CROSS_B;
      S_CROSS_B:   state_next = S_CROSS_CHK;
      S_CROSS_CHK: state_next = (cr_abs < CROSS_EPS) ? S_NEXT_OP : S_SIDE;
      S_SIDE: begin
        if (scnt == (cur_join ? 2'd3 : 2'd1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_take && last_emit) begin
          state_next = S_NEXT_OP;
        end
      end
      S_NEXT_OP: state_next = op_idx ? S_FINISH : S_SETUP;
      S_FINISH: begin
        if (can_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    point_ready = (state == S_IDLE);
    dir_start   = (state == S_DIR0) || (state == S_DIR1);
    ctl.push    = (state == S_EMIT) && can_take;
    ctl.flush   = (state == S_FINISH) && can_take;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: configuration and point state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stroke_width <= WIDTH_RESET;
      closed_path  <= 1'b0;
      base_index   <= '0;
      first_pt     <= '0;
      win0         <= '0;
      win1         <= '0;
      tail_pt      <= '0;
      seen         <= '0;
      nvi          <= '0;
      halted       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_STROKE_WIDTH: stroke_width <= pwdata[23:0];
          REG_CLOSED_PATH:  closed_path  <= pwdata[0];
          REG_BASE_INDEX: begin
            base_index <= pwdata[15:0];
            nvi        <= {1'b0, pwdata[15:0]};
            halted     <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == S_IDLE && point_valid && seen == 2'd0) begin
        first_pt <= '{x: point.point_x, y: point.point_y};
      end
      if (state == S_SETUP && op_run && cap_over) begin
        halted <= 1'b1;
      end
      if (ctl.push && is_vertex) begin
        nvi <= nvi + 17'd1;
      end
      if (state == S_FINISH && can_take) begin
        win0 <= win1;
        win1 <= cur_pt;
        if (cur_fin) begin
          seen <= '0;
          if (cur_join) begin
            halted <= 1'b0;
          end else begin
            tail_pt <= cur_pt;
          end
        end else begin
          seen <= (seen == 2'd2) ? 2'd2 : seen + 2'd1;
        end
      end
    end
  end

  // Working registers of the current item and operation.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (point_valid) begin
          cur_pt     <= '{x: point.point_x, y: point.point_y};
          cur_join   <= (point.opcode == OPC_JOIN);
          cur_fin    <= point.final_point;
          cur_closed <= closed_path;
          cur_c      <= seen;
          op_idx     <= 1'b0;
        end
      end
      S_SETUP: begin
        pa <= qa;
        pb <= qb;
        pc <= qc;
      end
      S_WAIT0: begin
        d0x  <= dir_ux;
        d0y  <= dir_uy;
        scnt <= '0;
      end
      S_WAIT1: begin
        d1x <= dir_ux;
        d1y <= dir_uy;
      end
      S_CROSS_A: prod1 <= prod;
      S_CROSS_B: cr <= 44'(prod1) - 44'(prod);
      S_SIDE: begin
        off[scnt] <= soff;
        scnt      <= scnt + 2'd1;
        vbase     <= nvi;
        ecnt      <= '0;
      end
      S_EMIT: begin
        if (can_take) begin
          ecnt <= ecnt + 3'd1;
        end
      end
      S_NEXT_OP: op_idx <= 1'b1;
      default: begin
      end
    endcase
  end

  psbb_dir u_dir (
    .clk   (clk),
    .rst   (rst),
    .start (dir_start),
    .dx    (dir_dx),
    .dy    (dir_dy),
    .done  (dir_done),
    .zero  (dir_zero),
    .ux    (dir_ux),
    .uy    (dir_uy)
  );

  psbb_out u_out (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .data       (emit_data),
    .can_take   (can_take),
    .mesh_valid (mesh_valid),
    .mesh_ready (mesh_ready),
    .mesh       (mesh)
  );

`ifndef ASSERT_OFF
  // Nothing is emitted while the band is halted.
  a_no_emit_halted: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !halted)
    else $error("result emitted while halted");

  // A push and the end-of-run flush never coincide.
  a_push_flush: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !ctl.flush)
    else $error("push and flush together");

  // After a point transaction the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |=> !point_ready)
    else $error("second point taken while busy");
`endif

endmodule

FILE: verif/polyline_stroke_band_bevel_tb.sv
// Testbench for the polyline stroke band: random and directed polylines checked against a predictor.
module polyline_stroke_band_bevel_tb;
  import psbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LONG  = 600;
  localparam int WATCH_LIMIT = 6000;
  localparam int SETTLE      = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_ready;
  point_in_t point = '0;
  logic mesh_valid;
  logic mesh_ready = 1'b0;
  mesh_out_t mesh;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  polyline_stroke_band_bevel dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_ready(point_ready), .point(point),
    .mesh_valid(mesh_valid), .mesh_ready(mesh_ready), .mesh(mesh),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores.
  point_in_t pending_points[$];
  mesh_out_t expected_mesh[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_req = 0;
  int stall_done = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // Predictor copy of configuration and band state.
  logic [23:0] cfg_width = WIDTH_RESET;
  logic        cfg_closed = 1'b0;
  pt_t         start_pt = '0;
  pt_t         win_prev = '0;
  pt_t         win_last = '0;
  pt_t         tail_pt = '0;
  int unsigned seen_cnt = 0;
  logic [16:0] vert_idx = '0;
  logic        band_halted = 1'b0;
  mesh_out_t   run_items[$];

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit direction in Q1.15; returns 0 for a zero-length vector.
  function automatic bit unit_vec(input longint dx, input longint dy,
                                  output longint ux, output longint uy);
    longint unsigned ax, ay, m, len, qx, qy;
    ux = 0;
    uy = 0;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax == 0 && ay == 0) return 1'b0;
    m = ax > ay ? ax : ay;
    while (m >= (64'd1 << 30)) begin
      ax = ax >> 1; ay = ay >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      ax = ax << 1; ay = ay << 1; m = m << 1;
    end
    len = root_floor(ax * ax + ay * ay);
    qx = (ax * 32768 + len / 2) / len;
    qy = (ay * 32768 + len / 2) / len;
    if (qx > 32768) qx = 32768;
    if (qy > 32768) qy = 32768;
    ux = dx < 0 ? -longint'(qx) : longint'(qx);
    uy = dy < 0 ? -longint'(qy) : longint'(qy);
    return 1'b1;
  endfunction

  function automatic longint half_offset(input longint u);
    longint unsigned mag;
    longint o;
    mag = u < 0 ? -u : u;
    o = longint'((mag * longint'(cfg_width) + 32768) >> 16);
    return u < 0 ? -o : o;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [15:0] add_vertex(input longint x, input longint y);
    mesh_out_t m;
    logic [15:0] idx;
    idx = vert_idx[15:0];
    m = '0;
    m.item_kind = KIND_VERTEX;
    m.vertex_x = clamp32(x);
    m.vertex_y = clamp32(y);
    m.index_a = idx;
    run_items.insert(run_items.size(), m);
    vert_idx = vert_idx + 17'd1;
    return idx;
  endfunction

  function automatic void add_triangle(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c);
    mesh_out_t m;
    m = '0;
    m.item_kind = KIND_TRIANGLE;
    m.index_a = a;
    m.index_b = b;
    m.index_c = c;
    run_items.insert(run_items.size(), m);
  endfunction

  // Quad of one segment from a to b.
  function automatic void stroke_segment(input pt_t a, input pt_t b);
    longint ux, uy, nx, ny;
    logic [15:0] a0, a1, b0, b1;
    if (cfg_width == 0 || band_halted) return;
    if (int'(vert_idx) + 4 > MESH_VERTEX_LIMIT_DEF) begin
      band_halted = 1'b1;
      return;
    end
    if (!unit_vec(longint'(b.x) - longint'(a.x), longint'(b.y) - longint'(a.y), ux, uy))
      return;
    nx = half_offset(-uy);
    ny = half_offset(ux);
    a0 = add_vertex(longint'(a.x) + nx, longint'(a.y) + ny);
    a1 = add_vertex(longint'(a.x) - nx, longint'(a.y) - ny);
    b0 = add_vertex(longint'(b.x) + nx, longint'(b.y) + ny);
    b1 = add_vertex(longint'(b.x) - nx, longint'(b.y) - ny);
    add_triangle(a0, b0, b1);
    add_triangle(a0, b1, a1);
  endfunction

  // Outer bevel wedge at corner c.
  function automatic void bevel_join(input pt_t p, input pt_t c, input pt_t n);
    longint d0x, d0y, d1x, d1y, cr, n0x, n0y, n1x, n1y;
    logic [15:0] ic, i0, i1;
    if (cfg_width == 0 || band_halted) return;
    if (int'(vert_idx) + 3 > MESH_VERTEX_LIMIT_DEF) begin
      band_halted = 1'b1;
      return;
    end
    if (!unit_vec(longint'(c.x) - longint'(p.x), longint'(c.y) - longint'(p.y), d0x, d0y))
      return;
    if (!unit_vec(longint'(n.x) - longint'(c.x), longint'(n.y) - longint'(c.y), d1x, d1y))
      return;
    cr = d0x * d1y - d0y * d1x;
    if ((cr < 0 ? -cr : cr) < longint'(CROSS_EPS)) return;
    n0x = half_offset(-d0y); n0y = half_offset(d0x);
    n1x = half_offset(-d1y); n1y = half_offset(d1x);
    if (cr > 0) begin
      n0x = -n0x; n0y = -n0y; n1x = -n1x; n1y = -n1y;
    end
    ic = add_vertex(longint'(c.x), longint'(c.y));
    i0 = add_vertex(longint'(c.x) + n0x, longint'(c.y) + n0y);
    i1 = add_vertex(longint'(c.x) + n1x, longint'(c.y) + n1y);
    add_triangle(ic, i0, i1);
  endfunction

  // Predict the mesh items caused by one accepted point.
  function automatic void stroke_point(input point_in_t t);
    pt_t p;
    int unsigned c;
    c = seen_cnt;
    p.x = t.point_x;
    p.y = t.point_y;
    run_items.delete();
    if (c == 0) start_pt = p;
    if (t.opcode == OPC_SEGMENT) begin
      if (c >= 1) stroke_segment(win_last, p);
      if (t.final_point) begin
        tail_pt = p;
        if (cfg_closed && c >= 1) stroke_segment(p, start_pt);
      end
    end else begin
      if (c == 1) begin
        if (cfg_closed) bevel_join(tail_pt, win_last, p);
      end else if (c >= 2) begin
        bevel_join(win_prev, win_last, p);
      end
      if (t.final_point && cfg_closed && c >= 1) bevel_join(win_last, p, start_pt);
    end
    win_prev = win_last;
    win_last = p;
    if (t.final_point) begin
      seen_cnt = 0;
      if (t.opcode == OPC_JOIN) band_halted = 1'b0;
    end else begin
      seen_cnt = c >= 2 ? 2 : c + 1;
    end
    if (run_items.size() > 0) run_items[run_items.size() - 1].last_of_run = 1'b1;
    foreach (run_items[i]) expected_mesh.insert(expected_mesh.size(), run_items[i]);
  endfunction

  // Point driver: predicts on acceptance, then offers the next queued point.
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || point_ready) begin
      if (point_valid) stroke_point(point);
      if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        point_valid <= 1'b1;
        point <= pending_points.pop_front();
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // Mesh monitor: checks each transaction and paces mesh_ready.
  always @(posedge clk) begin
    if (!rst && mesh_valid && mesh_ready) begin
      if (expected_mesh.size() == 0) begin
        $error("unexpected mesh transaction kind %0d index_a %0d", mesh.item_kind, mesh.index_a);
        errors++;
      end else begin
        mesh_out_t e;
        e = expected_mesh.pop_front();
        if (mesh.item_kind !== e.item_kind) begin
          $error("item_kind expected %0d got %0d", e.item_kind, mesh.item_kind); errors++;
        end
        if (mesh.vertex_x !== e.vertex_x) begin
          $error("vertex_x expected %0d got %0d", e.vertex_x, mesh.vertex_x); errors++;
        end
        if (mesh.vertex_y !== e.vertex_y) begin
          $error("vertex_y expected %0d got %0d", e.vertex_y, mesh.vertex_y); errors++;
        end
        if (mesh.index_a !== e.index_a) begin
          $error("index_a expected %0d got %0d", e.index_a, mesh.index_a); errors++;
        end
        if (mesh.index_b !== e.index_b) begin
          $error("index_b expected %0d got %0d", e.index_b, mesh.index_b); errors++;
        end
        if (mesh.index_c !== e.index_c) begin
          $error("index_c expected %0d got %0d", e.index_c, mesh.index_c); errors++;
        end
        if (mesh.last_of_run !== e.last_of_run) begin
          $error("last_of_run expected %0d got %0d", e.last_of_run, mesh.last_of_run); errors++;
        end
      end
    end
    if (stall_req != stall_done) begin
      stall_done <= stall_req;
      stall_left <= STALL_LONG;
      mesh_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      mesh_ready <= 1'b0;
    end else begin
      mesh_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transaction on the point, mesh or config channel.
  always @(posedge clk) begin
    if (rst || (point_valid && point_ready) || (mesh_valid && mesh_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("polyline_stroke_band_bevel_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every point is taken and every result has come, then let the block settle.
  task automatic drain();
    while (pending_points.size() > 0 || point_valid || expected_mesh.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_STROKE_WIDTH) begin
      cfg_width = value[23:0];
    end else if (idx == REG_CLOSED_PATH) begin
      cfg_closed = value[0];
    end else if (idx == REG_BASE_INDEX) begin
      vert_idx = {1'b0, value[15:0]};
      band_halted = 1'b0;
    end
  endtask

  function automatic void add_pt(input logic op, input longint x, input longint y,
                                 input logic fin);
    point_in_t t;
    t.opcode = op;
    t.point_x = x[31:0];
    t.point_y = y[31:0];
    t.final_point = fin;
    pending_points.insert(pending_points.size(), t);
  endfunction

  // One random polyline, mostly a segment pass and then a join pass; some give only the segment pass or random opcodes.
  function automatic int add_polyline();
    longint xs[8], ys[8];
    int n, style;
    longint sx, sy;
    n = $urandom_range(2, 6);
    style = $urandom_range(9);
    xs[0] = $signed($urandom());
    ys[0] = $signed($urandom());
    if (style < 7) begin
      xs[0] = $signed($urandom_range(0, 200000)) - 100000;
      ys[0] = $signed($urandom_range(0, 200000)) - 100000;
    end
    sx = $signed($urandom_range(0, 8000)) - 4000;
    sy = $signed($urandom_range(0, 8000)) - 4000;
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(5))
        0: begin xs[i] = xs[i-1]; ys[i] = ys[i-1]; end
        1: begin xs[i] = xs[i-1] + sx; ys[i] = ys[i-1] + sy; end
        2: begin xs[i] = $signed($urandom()); ys[i] = $signed($urandom()); end
        default: begin
          sx = $signed($urandom_range(0, 8000)) - 4000;
          sy = $signed($urandom_range(0, 8000)) - 4000;
          xs[i] = xs[i-1] + sx;
          ys[i] = ys[i-1] + sy;
        end
      endcase
    end
    if (style == 9) begin
      // Broken or mixed sequence: random opcodes and final marks.
      for (int i = 0; i < n; i++)
        add_pt(1'($urandom_range(1)), xs[i], ys[i], $urandom_range(3) == 0);
      return n;
    end
    for (int i = 0; i < n; i++) add_pt(OPC_SEGMENT, xs[i], ys[i], i == n - 1);
    if (style != 8)
      for (int i = 0; i < n; i++) add_pt(OPC_JOIN, xs[i], ys[i], i == n - 1);
    return style != 8 ? 2 * n : n;
  endfunction

  initial begin
    int count;
    logic [23:0] widths[8];
    logic [15:0] bases[8];
    widths = '{24'd256, 24'd0, 24'hFF_FFFF, 24'd1, 24'd3000, 24'd256, 24'd77777, 24'd512};
    bases = '{16'd0, 16'd100, 16'd65500, 16'hFFFF, 16'd1234, 16'd65480, 16'd0, 16'd40000};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: single point, extremes, zero length, straight and turning joins.
    add_pt(OPC_SEGMENT, 0, 0, 1'b1);
    add_pt(OPC_SEGMENT, 0, 0, 1'b0);
    add_pt(OPC_SEGMENT, 64'sd2147483647, -64'sd2147483648, 1'b1);
    add_pt(OPC_SEGMENT, -64'sd2147483648, 64'sd2147483647, 1'b0);
    add_pt(OPC_SEGMENT, -64'sd2147483648, 64'sd2147483647, 1'b0);
    add_pt(OPC_SEGMENT, 256, 0, 1'b1);
    add_pt(OPC_JOIN, 0, 0, 1'b0);
    add_pt(OPC_JOIN, 256, 0, 1'b0);
    add_pt(OPC_JOIN, 512, 0, 1'b0);
    add_pt(OPC_JOIN, 512, 256, 1'b1);
    write_reg(REG_CLOSED_PATH, 32'd1);
    // Closed path, join pass first without a fresh segment pass, then mixed opcodes.
    add_pt(OPC_JOIN, 0, 0, 1'b0);
    add_pt(OPC_JOIN, 2560, 0, 1'b1);
    add_pt(OPC_SEGMENT, 0, 0, 1'b0);
    add_pt(OPC_SEGMENT, 2560, 0, 1'b0);
    add_pt(OPC_SEGMENT, 2560, 2560, 1'b1);
    add_pt(OPC_JOIN, 0, 0, 1'b0);
    add_pt(OPC_SEGMENT, 2560, 0, 1'b0);
    add_pt(OPC_JOIN, 2560, 2560, 1'b1);
    write_reg(REG_STROKE_WIDTH, 32'd0);
    add_pt(OPC_SEGMENT, 0, 0, 1'b0);
    add_pt(OPC_SEGMENT, 900, 100, 1'b1);
    write_reg(REG_STROKE_WIDTH, 32'h00FF_FFFF);
    write_reg(REG_BASE_INDEX, 32'd65529);
    add_pt(OPC_SEGMENT, 0, 0, 1'b0);
    add_pt(OPC_SEGMENT, 1000, 0, 1'b0);
    add_pt(OPC_SEGMENT, 1000, 1000, 1'b1);
    add_pt(OPC_JOIN, 0, 0, 1'b0);
    add_pt(OPC_JOIN, 1000, 0, 1'b1);

    // Random phases over several settings and pacing modes.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_STROKE_WIDTH, {8'd0, widths[ph]});
      write_reg(REG_CLOSED_PATH, {31'd0, ph[0]});
      write_reg(REG_BASE_INDEX, {16'd0, bases[ph]});
      sender_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 45 : 37) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 45 : (ph % 4 == 3 ? 37 : 0);
      if (ph == 2) stall_req = stall_req + 1;
      count = 0;
      while (count < 40) count += add_polyline();
    end
    drain();

    if (errors == 0 && expected_mesh.size() == 0) begin
      $display("polyline_stroke_band_bevel_tb: PASS");
    end else begin
      $display("polyline_stroke_band_bevel_tb: FAIL");
    end
    $finish;
  end

endmodule
